FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check clocked on clk, idle while rst_n is low.
`define SPA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Concurrent check that also runs through reset.
`define SPA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define SPA_ASSERT(label, clk, rst_n, prop)
`define SPA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: design/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants of the segment/page address split unit.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_IN_W  = 4;
    localparam int TID_W     = 16;
    localparam int CFG_ADDR_W = 1;

    localparam int SEGMENT_ENTRIES_DEF = 16;

    localparam logic [DATA_W-1:0] MAX_SEG_SIZE_RST = 32'd1024;
    localparam logic [DATA_W-1:0] PAGE_SIZE_RST    = 32'd64;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_SEG_SIZE = 1'b0,
        CFG_PAGE_SIZE    = 1'b1
    } cfg_addr_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XLATE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        FAULT_OK      = 2'd0,
        FAULT_LENGTH  = 2'd1,
        FAULT_SEGMENT = 2'd2
    } fault_t;

    // Item carried beside the segment divider.
    typedef struct packed {
        op_t                 op;
        logic [IDX_IN_W-1:0] idx;
        logic [DATA_W-1:0]   len;
        logic [TID_W-1:0]    tid;
    } load_t;

    // Lookup status carried beside the page divider.
    typedef struct packed {
        fault_t            fault;
        logic [DATA_W-1:0] seg;
        logic [TID_W-1:0]  tid;
    } xlate_t;

endpackage

FILE: design/spa_divider.sv
// ----------------------------------------------------------------------------
// spa_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module spa_divider #(
    parameter int SIDE_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [spa_pkg::DATA_W-1:0] dividend,
    input  logic [spa_pkg::DATA_W-1:0] divisor,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_valid,
    output logic [spa_pkg::DATA_W-1:0] quotient,
    output logic [spa_pkg::DATA_W-1:0] remainder,
    output logic [SIDE_W-1:0]         side_out
);
    localparam int W = spa_pkg::DATA_W;

    logic [W-1:0]      valid_reg;
    logic [W-1:0]      rem_reg  [W];
    logic [W-1:0]      quo_reg  [W];
    logic [SIDE_W-1:0] side_reg [W];
    logic [W-1:0]      rem_next [W];
    logic [W-1:0]      quo_next [W];

    always_comb begin
        logic [W-1:0] prev_r;
        logic [W-1:0] prev_q;
        logic [W:0]   t;
        logic [W:0]   diff;
        logic         ge;
        for (int s = 0; s < W; s++) begin
            prev_r = (s == 0) ? '0 : rem_reg[(s == 0) ? 0 : s-1];
            prev_q = (s == 0) ? dividend : quo_reg[(s == 0) ? 0 : s-1];
            t      = {prev_r, prev_q[W-1]};
            diff   = t - {1'b0, divisor};
            ge     = (t >= {1'b0, divisor});
            rem_next[s] = ge ? diff[W-1:0] : t[W-1:0];
            quo_next[s] = {prev_q[W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < W; s++) begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
            side_reg[0] <= side_in;
            for (int s = 1; s < W; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign quotient  = quo_reg[W-1];
    assign remainder = rem_reg[W-1];
    assign side_out  = side_reg[W-1];

endmodule

FILE: design/spa_seg_table.sv
// ----------------------------------------------------------------------------
// spa_seg_table
// Segment table: applies loads in stream order and checks translations.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spa_seg_table #(
    parameter int SEGMENT_ENTRIES = spa_pkg::SEGMENT_ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  spa_pkg::load_t             load,
    input  logic [spa_pkg::DATA_W-1:0] seg,
    input  logic [spa_pkg::DATA_W-1:0] off,
    output logic                       out_valid,
    output spa_pkg::xlate_t            xlate,
    output logic [spa_pkg::DATA_W-1:0] page_dividend
);
    localparam int IDX_W = (SEGMENT_ENTRIES > 1) ? $clog2(SEGMENT_ENTRIES) : 1;
    localparam int W     = spa_pkg::DATA_W;

    logic [SEGMENT_ENTRIES-1:0] entry_valid_reg;
    logic [W-1:0]               len_mem [SEGMENT_ENTRIES];
    logic [spa_pkg::TID_W-1:0]  tid_mem [SEGMENT_ENTRIES];

    logic                       out_valid_reg;
    spa_pkg::xlate_t            xlate_reg;
    logic [W-1:0]               dividend_reg;

    logic                       is_load;
    logic                       load_in_range;
    logic [IDX_W-1:0]           load_addr;
    logic                       seg_in_range;
    logic [IDX_W-1:0]           seg_addr;
    logic                       seg_hit;
    spa_pkg::fault_t            fault;

    assign is_load       = (load.op == spa_pkg::OP_LOAD);
    assign load_in_range = (W'(load.idx) < W'(SEGMENT_ENTRIES));
    assign load_addr     = IDX_W'(load.idx);
    assign seg_in_range  = (seg < W'(SEGMENT_ENTRIES));
    assign seg_addr      = seg[IDX_W-1:0];
    assign seg_hit       = seg_in_range && entry_valid_reg[seg_addr];

    always_comb begin
        if (!seg_hit) begin
            fault = spa_pkg::FAULT_SEGMENT;
        end else if (off > len_mem[seg_addr]) begin
            fault = spa_pkg::FAULT_LENGTH;
        end else begin
            fault = spa_pkg::FAULT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else if (en) begin
            if (in_valid && is_load && load_in_range) begin
                entry_valid_reg[load_addr] <= 1'b1;
            end
            // drop loads here: they give no result
            out_valid_reg <= in_valid && !is_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid && is_load && load_in_range) begin
            len_mem[load_addr] <= load.len;
            tid_mem[load_addr] <= load.tid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xlate_reg.fault <= fault;
            xlate_reg.seg   <= seg;
            xlate_reg.tid   <= (fault == spa_pkg::FAULT_OK) ? tid_mem[seg_addr] : '0;
            dividend_reg    <= (fault == spa_pkg::FAULT_OK) ? off : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign xlate         = xlate_reg;
    assign page_dividend = dividend_reg;

    `SPA_ASSERT(a_load_no_result, aclk, aresetn,
        (en && in_valid && is_load) |=> !out_valid_reg)
    `SPA_ASSERT(a_fault_zero_tid, aclk, aresetn,
        (out_valid_reg && xlate_reg.fault != spa_pkg::FAULT_OK) |->
            (xlate_reg.tid == '0 && dividend_reg == '0))
    `SPA_ASSERT(a_load_sets_valid, aclk, aresetn,
        (en && in_valid && is_load && load_in_range) |=> entry_valid_reg[$past(load_addr)])

endmodule

FILE: design/segment_page_address_split_unit.sv
// Pipeline: 32 segment divider stages, one table stage, 32 page divider stages.
// Throughput: one item per cycle; each divider stage resolves one quotient bit.
// The whole pipeline holds while a result waits on m_tready.
// Reset: synchronous, active low; clears the segment table valid bits, all
// stage valid bits, and sets max_segment_size to 1024 and page_size to 64.
// ----------------------------------------------------------------------------
// segment_page_address_split_unit
// Splits logical addresses into segment, page number and page offset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_page_address_split_unit #(
    parameter int SEGMENT_ENTRIES = spa_pkg::SEGMENT_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [spa_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [spa_pkg::DATA_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // logical_address[31:0], entry_index[35:32], entry_length[67:36],
    // entry_table_id[83:68], zero fill
    input  logic [87:0]                    s_tdata,
    // op
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // segment_number[31:0], page_table_id[47:32], page_number[79:48],
    // page_offset[111:80]
    output logic [111:0]                   m_tdata,
    // fault_code
    output logic [1:0]                     m_tuser
);
    localparam int W = spa_pkg::DATA_W;

    logic [W-1:0]     max_seg_size_reg;
    logic [W-1:0]     page_size_reg;
    logic             en;
    spa_pkg::load_t   load_in;
    spa_pkg::load_t   load_d;
    logic             seg_valid;
    logic [W-1:0]     seg_q;
    logic [W-1:0]     seg_r;
    logic             tab_valid;
    spa_pkg::xlate_t  tab_xlate;
    logic [W-1:0]     tab_dividend;
    logic             pg_valid;
    logic [W-1:0]     pg_q;
    logic [W-1:0]     pg_r;
    spa_pkg::xlate_t  pg_xlate;
    logic             ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_seg_size_reg <= spa_pkg::MAX_SEG_SIZE_RST;
            page_size_reg    <= spa_pkg::PAGE_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (spa_pkg::cfg_addr_t'(cfg_addr))
                spa_pkg::CFG_MAX_SEG_SIZE: max_seg_size_reg <= cfg_wr_data;
                spa_pkg::CFG_PAGE_SIZE:    page_size_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // advance every stage unless a result is held at the output
    assign en       = !pg_valid || m_tready;
    assign s_tready = en;

    assign load_in.op  = spa_pkg::op_t'(s_tuser);
    assign load_in.idx = s_tdata[35:32];
    assign load_in.len = s_tdata[67:36];
    assign load_in.tid = s_tdata[83:68];

    spa_divider #(.SIDE_W($bits(spa_pkg::load_t))) u_seg_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .dividend  (s_tdata[31:0]),
        .divisor   (max_seg_size_reg),
        .side_in   (load_in),
        .out_valid (seg_valid),
        .quotient  (seg_q),
        .remainder (seg_r),
        .side_out  (load_d)
    );

    spa_seg_table #(.SEGMENT_ENTRIES(SEGMENT_ENTRIES)) u_table (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (seg_valid),
        .load          (load_d),
        .seg           (seg_q),
        .off           (seg_r),
        .out_valid     (tab_valid),
        .xlate         (tab_xlate),
        .page_dividend (tab_dividend)
    );

    spa_divider #(.SIDE_W($bits(spa_pkg::xlate_t))) u_page_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (tab_valid),
        .dividend  (tab_dividend),
        .divisor   (page_size_reg),
        .side_in   (tab_xlate),
        .out_valid (pg_valid),
        .quotient  (pg_q),
        .remainder (pg_r),
        .side_out  (pg_xlate)
    );

    assign ok       = (pg_xlate.fault == spa_pkg::FAULT_OK);
    assign m_tvalid = pg_valid;
    assign m_tuser  = pg_xlate.fault;
    assign m_tdata  = {ok ? pg_r : '0, ok ? pg_q : '0, pg_xlate.tid, pg_xlate.seg};

    `SPA_ASSERT(a_ready_follows_out, aclk, aresetn,
        s_tready == (!m_tvalid || m_tready))
    `SPA_ASSERT(a_fault_zero_fields, aclk, aresetn,
        (m_tvalid && m_tuser != spa_pkg::FAULT_OK) |-> (m_tdata[111:32] == '0))
    `SPA_ASSERT(a_hold_on_stall, aclk, aresetn,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

FILE: test/segment_page_address_split_unit_test.sv
// ----------------------------------------------------------------------------
// Segment/page address split unit testbench
// Loads segment table entries and translates addresses through the stream
// ports under changing divisor settings and random flow control. A local
// model of the table and both dividers predicts every translation result.
// ----------------------------------------------------------------------------
module segment_page_address_split_unit_test;

    localparam int N_SEG     = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 80;

    typedef struct packed {
        spa_pkg::op_t op;
        logic [31:0]  laddr;
        logic [3:0]   idx;
        logic [31:0]  len;
        logic [15:0]  tid;
    } access_t;

    typedef struct packed {
        spa_pkg::fault_t fault;
        logic [31:0]     seg;
        logic [15:0]     tid;
        logic [31:0]     page;
        logic [31:0]     poff;
    } xlate_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [0:0]   cfg_addr = '0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;

    segment_page_address_split_unit dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [31:0] seg_size_q = spa_pkg::MAX_SEG_SIZE_RST;
    logic [31:0] page_size_q = spa_pkg::PAGE_SIZE_RST;
    logic        tbl_valid [N_SEG];
    logic [31:0] tbl_len [N_SEG];
    logic [15:0] tbl_tid [N_SEG];

    access_t    pending_q [$];
    xlate_res_t expected_q [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int wdog = 0;
    bit timed_out = 0;
    logic s_tready_seen = 1'b0;

    function automatic void split_and_check(access_t a);
        xlate_res_t r;
        logic [31:0] off;
        if (a.op == spa_pkg::OP_LOAD) begin
            tbl_valid[a.idx] = 1'b1;
            tbl_len[a.idx] = a.len;
            tbl_tid[a.idx] = a.tid;
            return;
        end
        r = '0;
        r.seg = (seg_size_q == 0) ? 32'hFFFF_FFFF : a.laddr / seg_size_q;
        off = (seg_size_q == 0) ? a.laddr : a.laddr % seg_size_q;
        if (r.seg >= N_SEG || !tbl_valid[r.seg[3:0]]) begin
            r.fault = spa_pkg::FAULT_SEGMENT;
        end else if (off > tbl_len[r.seg[3:0]]) begin
            r.fault = spa_pkg::FAULT_LENGTH;
        end else begin
            r.fault = spa_pkg::FAULT_OK;
            r.tid = tbl_tid[r.seg[3:0]];
            r.page = (page_size_q == 0) ? 32'hFFFF_FFFF : off / page_size_q;
            r.poff = (page_size_q == 0) ? off : off % page_size_q;
        end
        expected_q.push_back(r);
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    access_t a;
                    a = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= a.op;
                    s_tdata <= {4'b0, a.tid, a.len, a.idx, a.laddr};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        xlate_res_t got, want;
        if (!aresetn) begin
            s_tready_seen <= 1'b0;
        end else begin
            s_tready_seen <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (s_tvalid && s_tready) begin
                split_and_check({spa_pkg::op_t'(s_tuser), s_tdata[31:0], s_tdata[35:32],
                                 s_tdata[67:36], s_tdata[83:68]});
            end
            if (m_tvalid && m_tready) begin
                got = {spa_pkg::fault_t'(m_tuser), m_tdata[31:0], m_tdata[47:32],
                       m_tdata[79:48], m_tdata[111:80]};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result fault=%0d seg=%0h", got.fault, got.seg);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp f=%0d seg=%h tid=%h pg=%h off=%h",
                                      " / got f=%0d seg=%h tid=%h pg=%h off=%h"},
                                     want.fault, want.seg, want.tid, want.page, want.poff,
                                     got.fault, got.seg, got.tid, got.page, got.poff);
                    end
                end
            end
            if (wdog >= WDOG_MAX) timed_out = 1;
        end
    end

    task automatic write_reg(spa_pkg::cfg_addr_t a, logic [31:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (a == spa_pkg::CFG_MAX_SEG_SIZE) seg_size_q = v; else page_size_q = v;
    endtask

    task automatic add_load(logic [3:0] idx, logic [31:0] len, logic [15:0] tid);
        access_t a;
        a = '{op: spa_pkg::OP_LOAD, laddr: $urandom(), idx: idx, len: len, tid: tid};
        pending_q.push_back(a);
    endtask

    task automatic add_xlate(logic [31:0] laddr);
        access_t a;
        a = '{op: spa_pkg::OP_XLATE, laddr: laddr, idx: 4'($urandom()),
              len: $urandom(), tid: 16'($urandom())};
        pending_q.push_back(a);
    endtask

    // hold until everything sent has come back, then let the pipe empty
    task automatic wait_idle();
        while ((pending_q.size() > 0 || s_tvalid || expected_q.size() > 0) && !timed_out)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // mostly addresses in or just past the table's segments, plus some loads and random addresses
    task automatic random_phase(int n);
        logic [31:0] seg, off;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1: add_load(4'($urandom()), ($urandom_range(1) ? $urandom() :
                               $urandom_range(seg_size_q > 4 ? 2 * seg_size_q : 8)),
                               16'($urandom()));
                2: add_xlate($urandom());
                default: begin
                    seg = $urandom_range(N_SEG + 1);
                    off = (seg_size_q == 0) ? $urandom() : $urandom_range(seg_size_q - 1);
                    if (seg_size_q == 0) add_xlate(off);
                    else add_xlate(seg * seg_size_q + off);
                end
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < N_SEG; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_len[i] = '0;
            tbl_tid[i] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: unloaded, out of range, length boundary, both extremes
        add_xlate(32'd0);
        add_xlate(32'hFFFF_FFFF);
        add_load(4'd0, 32'd100, 16'hFFFF);
        add_load(4'd15, 32'hFFFF_FFFF, 16'h0000);
        add_load(4'd3, 32'd0, 16'hA5A5);
        add_xlate(32'd100);
        add_xlate(32'd101);
        add_xlate(32'd0);
        add_xlate(15 * 1024 + 1023);
        add_xlate(3 * 1024);
        add_xlate(3 * 1024 + 1);
        add_xlate(16 * 1024);
        add_xlate(5 * 1024 + 7);
        wait_idle();

        write_reg(spa_pkg::CFG_MAX_SEG_SIZE, 32'd0);
        write_reg(spa_pkg::CFG_PAGE_SIZE, 32'd0);
        add_xlate(32'd5);
        add_xlate(32'hFFFF_FFFF);
        wait_idle();
        write_reg(spa_pkg::CFG_MAX_SEG_SIZE, 32'hFFFF_FFFF);
        add_xlate(32'hFFFF_FFFE);
        add_xlate(32'hFFFF_FFFF);
        wait_idle();
        write_reg(spa_pkg::CFG_PAGE_SIZE, 32'hFFFF_FFFF);
        wait_idle();
        write_reg(spa_pkg::CFG_PAGE_SIZE, 32'd1);
        add_load(4'd1, 32'h0FFF_FFFF, 16'h1234);
        add_xlate(32'hFFFF_FFFF);
        add_xlate(32'd77);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            case (ph)
                0: begin
                    write_reg(spa_pkg::CFG_MAX_SEG_SIZE, 32'd1024);
                    write_reg(spa_pkg::CFG_PAGE_SIZE, 32'd64);
                end
                1: begin
                    write_reg(spa_pkg::CFG_MAX_SEG_SIZE, 32'd1);
                    write_reg(spa_pkg::CFG_PAGE_SIZE, 32'd1);
                end
                2: begin
                    write_reg(spa_pkg::CFG_MAX_SEG_SIZE, 32'd100000);
                    write_reg(spa_pkg::CFG_PAGE_SIZE, 32'd4096);
                end
                3: begin
                    write_reg(spa_pkg::CFG_MAX_SEG_SIZE, 32'h1000_0000);
                    write_reg(spa_pkg::CFG_PAGE_SIZE, 32'd0);
                end
                4: begin
                    write_reg(spa_pkg::CFG_MAX_SEG_SIZE, $urandom_range(20000, 3));
                    write_reg(spa_pkg::CFG_PAGE_SIZE, $urandom_range(300, 1));
                end
                5: begin
                    write_reg(spa_pkg::CFG_MAX_SEG_SIZE, 32'd7);
                    write_reg(spa_pkg::CFG_PAGE_SIZE, 32'hFFFF_FFFF);
                end
                6: begin
                    write_reg(spa_pkg::CFG_MAX_SEG_SIZE, 32'h0FFF_FFFF);
                    write_reg(spa_pkg::CFG_PAGE_SIZE, $urandom());
                end
                default: begin
                    write_reg(spa_pkg::CFG_MAX_SEG_SIZE, $urandom_range(5000, 16));
                    write_reg(spa_pkg::CFG_PAGE_SIZE, 32'd3);
                end
            endcase
            random_phase(78);
            wait_idle();
        end

        if (timed_out) begin
            $display("Regression FAIL");
        end else if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("Regression FAIL");
        $finish;
    end
endmodule
